// ===== sv/bav_pkg.sv =====
// Package for the advertising data validator.
// Holds the AD type codes, the parser's status struct and the length/type check.
// No dependencies.
package bav_pkg;

  localparam int ByteW = 8;
  localparam int CountW = 9;
  localparam logic [ByteW-1:0] MaxSizeReset = 8'd31;

  // AD type codes from the assigned numbers.
  localparam logic [ByteW-1:0] AdFlags = 8'h01;
  localparam logic [ByteW-1:0] AdUuid16Part = 8'h02;
  localparam logic [ByteW-1:0] AdUuid16Full = 8'h03;
  localparam logic [ByteW-1:0] AdNameShort = 8'h08;
  localparam logic [ByteW-1:0] AdNameFull = 8'h09;
  localparam logic [ByteW-1:0] AdTxPower = 8'h0A;
  localparam logic [ByteW-1:0] AdConnInterval = 8'h12;
  localparam logic [ByteW-1:0] AdServiceData16 = 8'h16;
  localparam logic [ByteW-1:0] AdManufacturer = 8'hFF;

  // Value sizes, exact or minimum, that the type checks demand.
  localparam logic [ByteW-1:0] SizeOne = 8'd1;
  localparam logic [ByteW-1:0] SizeConnInterval = 8'd5;
  localparam logic [ByteW-1:0] SizeServiceMin = 8'd3;

  typedef struct packed {
    logic done;   // the byte just taken closed a buffer
    logic valid;  // verdict for that buffer
  } bav_verdict_t;

  // True when a structure of length len and type ad_type is well formed.
  function automatic logic len_fits_type(input logic [ByteW-1:0] ad_type,
                                         input logic [ByteW-1:0] len,
                                         input logic [ByteW-1:0] max_size);
    logic [ByteW-1:0] vsize;
    logic ok;
    vsize = len - 8'd1;
    case (ad_type) inside
      AdFlags, AdTxPower: ok = (vsize == SizeOne);
      AdConnInterval: ok = (vsize == SizeConnInterval);
      AdUuid16Part, AdUuid16Full: ok = (vsize != '0) && !vsize[0];
      AdServiceData16: ok = (vsize >= SizeServiceMin);
      AdNameShort, AdNameFull, AdManufacturer: ok = (vsize >= SizeOne);
      default: ok = 1'b0;
    endcase
    if ((len == '0) || (({1'b0, len} + 9'd1) > {1'b0, max_size})) begin
      ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

// ===== sv/bav_parser.sv =====
// AD structure parser: holds the per-buffer parse state and updates it
// once per byte. Depends on bav_pkg.
module bav_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [bav_pkg::ByteW-1:0] byte_value,
  input  logic                      last_byte,
  input  logic [bav_pkg::ByteW-1:0] max_size,
  output bav_pkg::bav_verdict_t     verdict
);

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_TYPE = 2'd1,
    PH_VAL  = 2'd2
  } phase_t;

  logic [bav_pkg::CountW-1:0] byte_count, byte_count_next;
  phase_t                     phase, phase_next;
  logic [bav_pkg::ByteW-1:0]  struct_length, struct_length_next;
  logic [bav_pkg::ByteW-1:0]  value_left, value_left_next;
  logic                       failed, failed_next;

  always_comb begin
    byte_count_next = (byte_count == '1) ? byte_count : byte_count + 9'd1;
    failed_next = failed || (byte_count_next > {1'b0, max_size});
    phase_next = phase;
    struct_length_next = struct_length;
    value_left_next = value_left;
    unique case (phase)
      PH_TYPE: begin
        if (!bav_pkg::len_fits_type(byte_value, struct_length, max_size)) begin
          failed_next = 1'b1;
        end
        value_left_next = struct_length - 8'd1;
        phase_next = (value_left_next == '0) ? PH_LEN : PH_VAL;
      end
      PH_VAL: begin
        value_left_next = value_left - 8'd1;
        if (value_left_next == '0) begin
          phase_next = PH_LEN;
        end
      end
      default: begin
        // A length byte that closes the buffer can never be followed by its type.
        if ((byte_value == '0) || (({1'b0, byte_value} + 9'd1) > {1'b0, max_size}) ||
            last_byte) begin
          failed_next = 1'b1;
        end
        struct_length_next = byte_value;
        phase_next = PH_TYPE;
      end
    endcase
  end

  assign verdict.done = step && last_byte;
  assign verdict.valid = !failed_next && (phase_next == PH_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      phase <= PH_LEN;
      struct_length <= '0;
      value_left <= '0;
      failed <= 1'b0;
    end else if (step) begin
      if (last_byte) begin
        byte_count <= '0;
        phase <= PH_LEN;
        struct_length <= '0;
        value_left <= '0;
        failed <= 1'b0;
      end else begin
        byte_count <= byte_count_next;
        phase <= phase_next;
        struct_length <= struct_length_next;
        value_left <= value_left_next;
        failed <= failed_next;
      end
    end
  end

endmodule

// ===== sv/ble_adv_data_validator.sv =====
// Advertising data validator, top level: input register, parser and verdict register.
// A last byte is held in the input register, and its verdict is then stored in the
// verdict register that drives the output. Throughput: one byte per cycle; a byte that ends no
// buffer always moves on, and a last byte waits only while an earlier verdict is stalled.
// Reset (rst, synchronous) empties both registers, clears the parse state and
// sets max_size to 31. Depends on bav_pkg and bav_parser.
module ble_adv_data_validator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [bav_pkg::ByteW-1:0] byte_value,
  input  logic                      last_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      buffer_valid,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bav_pkg::ByteW-1:0] max_size
);

  logic [bav_pkg::ByteW-1:0] max_size_reg;
  logic                      s1_valid;
  logic [bav_pkg::ByteW-1:0] s1_byte;
  logic                      s1_last;
  logic                      s1_step;
  logic                      in_take;
  bav_pkg::bav_verdict_t     verdict;

  assign cfg_ready = 1'b1;

  // A non-final byte never produces a result, so it can always move on.
  assign s1_step = s1_valid && (!s1_last || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_step;
  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_size_reg <= bav_pkg::MaxSizeReset;
    end else if (cfg_valid && cfg_ready) begin
      max_size_reg <= max_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= byte_value;
      s1_last <= last_byte;
    end
  end

  bav_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (s1_step),
    .byte_value (s1_byte),
    .last_byte  (s1_last),
    .max_size   (max_size_reg),
    .verdict    (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (verdict.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (verdict.done) begin
      buffer_valid <= verdict.valid;
    end
  end

endmodule
